>>> design/assert_macros.svh
// Assertion helpers for the design files; euler_to_unit_quaternion includes them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, off during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> design/e2q_pkg.sv
// ----------------------------------------------------------------------------
// e2q_pkg: shared constants and tables
// Formats, angle constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package e2q_pkg;
	localparam int CordicStagesDef = 16;
	localparam int AtanLen = 24;
	localparam int signed HalfTurn = 23040;
	localparam int signed QuarterTurn = 11520;
	localparam int signed FullTurn = 46080;
	localparam longint RadPerUnit = 146409;
	localparam longint GainInv = 652032874;
	localparam int One14 = 16384;
	// Q30 sine/cosine width
	localparam int TrigW = 34;
	// Components in Q20
	localparam int CompW = 24;
	localparam int SqW = 50;
	localparam int MagW = 25;

	function automatic logic signed [TrigW-1:0] atan_q30(input int i);
		logic signed [TrigW-1:0] t [AtanLen];
		t = '{34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
			34'sd67021686, 34'sd33543515, 34'sd16775850, 34'sd8388437,
			34'sd4194282, 34'sd2097149, 34'sd1048575, 34'sd524287,
			34'sd262143, 34'sd131071, 34'sd65535, 34'sd32767, 34'sd16383,
			34'sd8191, 34'sd4095, 34'sd2047, 34'sd1023, 34'sd511, 34'sd255,
			34'sd127};
		return t[i];
	endfunction

	typedef struct packed {
		logic signed [TrigW-1:0] x;
		logic signed [TrigW-1:0] y;
		logic signed [TrigW-1:0] z;
	} cordic_t;
endpackage

>>> design/e2q_cordic_cell.sv
// ----------------------------------------------------------------------------
// e2q_cordic_cell: one CORDIC rotation stage
// Rotates x/y toward the residual angle z by atan(2^-SHIFT), registered.
// ----------------------------------------------------------------------------
module e2q_cordic_cell #(
	parameter int SHIFT = 0
) (
	input  logic               clk,
	input  e2q_pkg::cordic_t   d,
	output e2q_pkg::cordic_t   q
);
	import e2q_pkg::*;
	cordic_t nxt;

	// Step toward zero residual
	always_comb begin
		nxt = d;
		if (!d.z[TrigW-1]) begin
			nxt.x = d.x - (d.y >>> SHIFT);
			nxt.y = d.y + (d.x >>> SHIFT);
			nxt.z = d.z - atan_q30(SHIFT);
		end else begin
			nxt.x = d.x + (d.y >>> SHIFT);
			nxt.y = d.y - (d.x >>> SHIFT);
			nxt.z = d.z + atan_q30(SHIFT);
		end
	end

	always_ff @(posedge clk) begin
		q <= nxt;
	end
endmodule

>>> design/e2q_sincos.sv
// ----------------------------------------------------------------------------
// e2q_sincos: half-angle sine and cosine
// Folds the angle, runs a chain of CORDIC cells, applies the fold sign.
// ----------------------------------------------------------------------------
module e2q_sincos #(
	parameter int STAGES = e2q_pkg::CordicStagesDef
) (
	input  logic                               clk,
	input  logic signed [15:0]                 ang,
	output logic signed [e2q_pkg::TrigW-1:0]   cos_o,
	output logic signed [e2q_pkg::TrigW-1:0]   sin_o
);
	import e2q_pkg::*;
	localparam int N = (STAGES > AtanLen) ? AtanLen : STAGES;

	logic signed [17:0] h;
	logic               flip;
	cordic_t            chain [N+1];
	logic               flip_s [N+1];

	// Wrap by a full turn, then fold into +/-90 degrees
	always_comb begin
		h = 18'(ang);
		flip = 1'b0;
		if (h >= 18'(HalfTurn)) h = h - 18'(FullTurn);
		if (h < -18'(HalfTurn)) h = h + 18'(FullTurn);
		if (h > 18'(QuarterTurn)) begin
			h = h - 18'(HalfTurn);
			flip = 1'b1;
		end else if (h < -18'(QuarterTurn)) begin
			h = h + 18'(HalfTurn);
			flip = 1'b1;
		end
	end

	// Register the starting vector
	always_ff @(posedge clk) begin
		chain[0].x <= TrigW'(GainInv);
		chain[0].y <= '0;
		chain[0].z <= TrigW'(h) * TrigW'(RadPerUnit);
		flip_s[0] <= flip;
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		e2q_cordic_cell #(.SHIFT(i)) u_cell (.clk(clk), .d(chain[i]), .q(chain[i+1]));
		always_ff @(posedge clk) begin
			flip_s[i+1] <= flip_s[i];
		end
	end

	assign cos_o = flip_s[N] ? -chain[N].x : chain[N].x;
	assign sin_o = flip_s[N] ? -chain[N].y : chain[N].y;
endmodule

>>> design/e2q_norm.sv
// ----------------------------------------------------------------------------
// e2q_norm: quaternion assembly and normalization
// Triple products, sum of squares, pipelined square root and dividers.
// ----------------------------------------------------------------------------
module e2q_norm (
	input  logic                               clk,
	input  logic signed [e2q_pkg::TrigW-1:0]   cp,
	input  logic signed [e2q_pkg::TrigW-1:0]   sp,
	input  logic signed [e2q_pkg::TrigW-1:0]   cy,
	input  logic signed [e2q_pkg::TrigW-1:0]   sy,
	input  logic signed [e2q_pkg::TrigW-1:0]   cr,
	input  logic signed [e2q_pkg::TrigW-1:0]   sr,
	output logic signed [15:0]                 qx,
	output logic signed [15:0]                 qy,
	output logic signed [15:0]                 qz,
	output logic signed [15:0]                 qw
);
	import e2q_pkg::*;
	localparam int SqrtN = SqW / 2;
	localparam int DivN = 16;
	localparam int NumW = CompW + 15;

	// Pair products of roll with pitch, Q30
	logic signed [TrigW-1:0] pp_s1 [4];
	logic signed [TrigW-1:0] cy_s1, sy_s1;
	always_ff @(posedge clk) begin
		pp_s1[0] <= TrigW'((68'(sr) * 68'(cp)) >>> 30);
		pp_s1[1] <= TrigW'((68'(cr) * 68'(sp)) >>> 30);
		pp_s1[2] <= TrigW'((68'(cr) * 68'(cp)) >>> 30);
		pp_s1[3] <= TrigW'((68'(sr) * 68'(sp)) >>> 30);
		cy_s1 <= cy;
		sy_s1 <= sy;
	end

	// Triple products: apply yaw last
	logic signed [TrigW-1:0] t_s2 [8];
	always_ff @(posedge clk) begin
		t_s2[0] <= TrigW'((68'(pp_s1[0]) * 68'(cy_s1)) >>> 30);
		t_s2[1] <= TrigW'((68'(pp_s1[1]) * 68'(sy_s1)) >>> 30);
		t_s2[2] <= TrigW'((68'(pp_s1[1]) * 68'(cy_s1)) >>> 30);
		t_s2[3] <= TrigW'((68'(pp_s1[0]) * 68'(sy_s1)) >>> 30);
		t_s2[4] <= TrigW'((68'(pp_s1[2]) * 68'(sy_s1)) >>> 30);
		t_s2[5] <= TrigW'((68'(pp_s1[3]) * 68'(cy_s1)) >>> 30);
		t_s2[6] <= TrigW'((68'(pp_s1[2]) * 68'(cy_s1)) >>> 30);
		t_s2[7] <= TrigW'((68'(pp_s1[3]) * 68'(sy_s1)) >>> 30);
	end

	// Components in Q20
	logic signed [CompW-1:0] c_s3 [4];
	always_ff @(posedge clk) begin
		c_s3[0] <= CompW'((t_s2[0] - t_s2[1]) >>> 10);
		c_s3[1] <= CompW'((t_s2[2] + t_s2[3]) >>> 10);
		c_s3[2] <= CompW'((t_s2[4] - t_s2[5]) >>> 10);
		c_s3[3] <= CompW'((t_s2[6] + t_s2[7]) >>> 10);
	end

	// Squares
	logic [SqW-1:0] sq_s4 [4];
	logic signed [CompW-1:0] c_s4 [4];
	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			sq_s4[k] <= SqW'(48'(c_s3[k]) * 48'(c_s3[k]));
			c_s4[k] <= c_s3[k];
		end
	end

	// Sum of squares
	logic [SqW-1:0] m2_s5;
	logic signed [CompW-1:0] c_s5 [4];
	always_ff @(posedge clk) begin
		m2_s5 <= sq_s4[0] + sq_s4[1] + sq_s4[2] + sq_s4[3];
		c_s5 <= c_s4;
	end

	// Restoring square root, one result bit per stage
	logic [SqW-1:0] rn [SqrtN+1];
	logic [MagW:0]  rr [SqrtN+1];
	logic signed [CompW-1:0] rc [SqrtN+1][4];
	assign rn[0] = m2_s5;
	assign rr[0] = '0;
	assign rc[0] = c_s5;
	for (genvar i = 0; i < SqrtN; i++) begin : g_sqrt
		localparam int Sh = 2 * (SqrtN - 1 - i);
		logic [SqW+1:0] trial;
		logic [SqW+1:0] rem;
		always_comb begin
			trial = ((SqW+2)'(rr[i]) << 2 | 1) << Sh;
			rem = (SqW+2)'(rn[i]);
		end
		always_ff @(posedge clk) begin
			if (rem >= trial) begin
				rn[i+1] <= SqW'(rem - trial);
				rr[i+1] <= (MagW+1)'(rr[i] << 1 | 1);
			end else begin
				rn[i+1] <= rn[i];
				rr[i+1] <= (MagW+1)'(rr[i] << 1);
			end
			rc[i+1] <= rc[i];
		end
	end

	// Rounded numerators
	logic [MagW-1:0] mag_s6;
	logic [NumW-1:0] num_s6 [4];
	logic            neg_s6 [4];
	logic            zero_s6;
	always_ff @(posedge clk) begin
		mag_s6 <= MagW'(rr[SqrtN]);
		zero_s6 <= (rr[SqrtN] == '0);
		for (int k = 0; k < 4; k++) begin
			neg_s6[k] <= rc[SqrtN][k][CompW-1];
			num_s6[k] <= (NumW'(rc[SqrtN][k][CompW-1] ? -rc[SqrtN][k] : rc[SqrtN][k]) << 14)
				+ NumW'(rr[SqrtN] >> 1);
		end
	end

	// Quotient: saturated 15-bit result, one bit per stage (bit 14 down to 0); the last stage only passes on
	logic [NumW-1:0] dn [DivN+1][4];
	logic [15:0]     dq [DivN+1][4];
	logic [MagW-1:0] dm [DivN+1];
	logic            dneg [DivN+1][4];
	logic            dz [DivN+1];
	logic            dsat [DivN+1][4];
	always_comb begin
		dm[0] = mag_s6;
		dz[0] = zero_s6;
		for (int k = 0; k < 4; k++) begin
			dn[0][k] = num_s6[k];
			dq[0][k] = '0;
			dneg[0][k] = neg_s6[k];
			dsat[0][k] = (num_s6[k] >= (NumW'(mag_s6) << 14));
		end
	end
	for (genvar i = 0; i < DivN; i++) begin : g_div
		localparam int B = DivN - 2 - i;
		always_ff @(posedge clk) begin
			dm[i+1] <= dm[i];
			dz[i+1] <= dz[i];
			for (int k = 0; k < 4; k++) begin
				dneg[i+1][k] <= dneg[i][k];
				dsat[i+1][k] <= dsat[i][k];
				dn[i+1][k] <= dn[i][k];
				dq[i+1][k] <= dq[i][k];
				if (B >= 0) begin
					if (dn[i][k] >= (NumW'(dm[i]) << B)) begin
						dn[i+1][k] <= dn[i][k] - (NumW'(dm[i]) << B);
						dq[i+1][k] <= dq[i][k] | (16'd1 << B);
					end
				end
			end
		end
	end

	// Sign, saturation and zero magnitude
	logic [15:0] mq [4];
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			mq[k] = dsat[DivN][k] ? 16'(One14) : dq[DivN][k];
			if (dz[DivN]) mq[k] = '0;
			else if (dneg[DivN][k]) mq[k] = -mq[k];
		end
	end
	assign qx = mq[0];
	assign qy = mq[1];
	assign qz = mq[2];
	assign qw = mq[3];
endmodule

>>> design/euler_to_unit_quaternion.sv
// A beat passes CORDIC_STAGES + 51 registers (stages capped at 24): STAGES + 1
// CORDIC, 5 product/sum, 25 square-root, 17 divide, 3 result buffer. Throughput one
// beat per cycle while in_ready is high. The pipeline runs free; in_ready drops once
// CORDIC_STAGES + 52 beats are outstanding. Reset clears valid bits, counters and
// FIFO pointers; data registers are not reset.
// ----------------------------------------------------------------------------
// euler_to_unit_quaternion: Euler ZYX angles to unit quaternion
// Pipelined CORDIC, products, square root and divide, one beat per cycle while in_ready is high.
// ----------------------------------------------------------------------------
module euler_to_unit_quaternion #(
	parameter int CORDIC_STAGES = e2q_pkg::CordicStagesDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] pitch_deg,
	input  logic signed [15:0] yaw_deg,
	input  logic signed [15:0] roll_deg,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] quat_x,
	output logic signed [15:0] quat_y,
	output logic signed [15:0] quat_z,
	output logic signed [15:0] quat_w
);
	import e2q_pkg::*;
	`include "assert_macros.svh"
	localparam int N = (CORDIC_STAGES > AtanLen) ? AtanLen : CORDIC_STAGES;
	localparam int Lat = N + 1 + 5 + 25 + 17;
	localparam int Limit = Lat + 4;
	localparam int CntW = $clog2(Limit + 1) + 1;

	// Half angle: ports in 1/64 deg read directly as the half angle in 1/128 deg
	logic signed [15:0] p_h, y_h, r_h;
	assign p_h = pitch_deg;
	assign y_h = yaw_deg;
	assign r_h = roll_deg;

	logic signed [TrigW-1:0] cp, sp, cy, sy, cr, sr;
	logic signed [15:0] qx, qy, qz, qw;
	e2q_sincos #(.STAGES(N)) u_p (.clk(clk), .ang(p_h), .cos_o(cp), .sin_o(sp));
	e2q_sincos #(.STAGES(N)) u_y (.clk(clk), .ang(y_h), .cos_o(cy), .sin_o(sy));
	e2q_sincos #(.STAGES(N)) u_r (.clk(clk), .ang(r_h), .cos_o(cr), .sin_o(sr));
	e2q_norm u_norm (.clk(clk), .cp(cp), .sp(sp), .cy(cy), .sy(sy), .cr(cr), .sr(sr),
		.qx(qx), .qy(qy), .qz(qz), .qw(qw));

	// Track beats in flight; the pipeline runs free, results land in a FIFO
	logic [Lat-1:0] vld_q;
	logic [CntW-1:0] cnt_q;
	logic acc, pop;
	assign acc = in_valid && in_ready;
	assign pop = out_valid && out_ready;
	assign in_ready = (cnt_q < CntW'(Limit));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			cnt_q <= '0;
		end else begin
			vld_q <= {vld_q[Lat-2:0], acc};
			cnt_q <= cnt_q + CntW'(acc) - CntW'(pop);
		end
	end

	// Result FIFO with registered read, deep enough for every outstanding beat
	localparam int AW = $clog2(Limit);
	localparam int Depth = 1 << AW;
	logic [63:0] mem [Depth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] fc_q;
	logic [63:0] rd_q, out_q;
	logic rdv_q, ov_q;
	logic mv, rd_en;
	assign mv = rdv_q && (!ov_q || out_ready);
	assign rd_en = (fc_q != '0) && (!rdv_q || mv);

	// Write results, read into the staging register, advance to the output register
	always_ff @(posedge clk) begin
		if (vld_q[Lat-1]) mem[wp_q] <= {qx, qy, qz, qw};
		if (rd_en) rd_q <= mem[rp_q];
		if (mv) out_q <= rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			fc_q <= '0;
			rdv_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (vld_q[Lat-1]) wp_q <= wp_q + 1'b1;
			if (rd_en) rp_q <= rp_q + 1'b1;
			fc_q <= fc_q + (AW+1)'(vld_q[Lat-1]) - (AW+1)'(rd_en);
			if (rd_en) rdv_q <= 1'b1;
			else if (mv) rdv_q <= 1'b0;
			if (mv) ov_q <= 1'b1;
			else if (pop) ov_q <= 1'b0;
		end
	end
	assign out_valid = ov_q;
	assign quat_x = out_q[63:48];
	assign quat_y = out_q[47:32];
	assign quat_z = out_q[31:16];
	assign quat_w = out_q[15:0];

	`ASSERT_IMPL(a_fifo_room, clk, arst_n, 1'b1, fc_q <= (AW+1)'(Depth), "result FIFO overflow")
	`ASSERT_IMPL(a_cnt_cover, clk, arst_n, 1'b1, CntW'(fc_q) <= cnt_q, "beat count below FIFO fill")
	`ASSERT_NEXT(a_pop_cnt, clk, arst_n, pop && !acc, cnt_q == $past(cnt_q) - 1'b1, "count lost a beat")
endmodule
